[sv/scm_pkg.sv]
// ----------------------------------------------------------------------------
// Sample channel mixer package
// Shared widths, operation and register codes, arithmetic constants and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

    // Default values for the top-level parameters.
    localparam int CHANNELS_DEF   = 8;
    localparam int LEVELS_DEF     = 8;
    localparam int MEM_DEPTH_DEF  = 65536;

    // Field widths.
    localparam int OP_W       = 2;
    localparam int SAMPLE_W   = 16;
    localparam int CH_IN_W    = 3;
    localparam int LEVEL_W    = 3;
    localparam int ADDR_W     = 16;
    localparam int LEN_W      = 17;
    localparam int BYTE_W     = 8;
    localparam int ACTIVE_W   = 8;
    localparam int GAIN_W     = 13;
    localparam int STEP_W     = 21;
    localparam int PHASE_W    = 16;
    localparam int ADV_W      = STEP_W + 1 - PHASE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // Mix arithmetic.
    localparam int MIX_SHIFT   = 12;
    localparam int BYTE_SHIFT  = 8;
    localparam int ACC_W       = 36;
    localparam int PROD_W      = GAIN_W + LEVEL_W + 1;
    localparam int RECIP_SHIFT = 24;
    localparam int PIPE_DRAIN  = 4;
    localparam int DRAIN_W     = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_MIX   = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP   = 3'd4;

    // Register reset values.
    localparam logic [GAIN_W-1:0] MUSIC_GAIN_RST  = 13'd4096;
    localparam logic [GAIN_W-1:0] SAMPLE_GAIN_RST = 13'd4096;
    localparam logic [STEP_W-1:0] SAMPLE_STEP_RST = 21'd65536;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_mix;
        logic do_start;
        logic do_write;
        logic visit;
        logic finish;
    } t_cmd;

endpackage

`default_nettype wire

[sv/sample_channel_mixer_core.sv]
// ----------------------------------------------------------------------------
// Sample channel mixer core
// Mixes a music sample with signed 8-bit sample channels read from a
// byte-wide sample memory.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Memory writes
// and channel starts produce no result; a memory write passes through the
// stage-1 registers before it lands, in time for any following mix.
// A mix visits one channel per clock and runs them through a five-stage
// pipeline (address reduction, memory read, level divide, multiply,
// accumulate); o_valid rises after the channel visits, the pipeline drain
// and the finish state and stays for exactly one cycle, and no operation is
// taken before then. The result must be captured in that cycle: there is no
// backpressure on the result side. Configuration writes are taken at any
// time but must only be made while no mix is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_channel_mixer_core #(
    parameter int CHANNELS         = scm_pkg::CHANNELS_DEF,
    parameter int LEVELS           = scm_pkg::LEVELS_DEF,
    parameter int SAMPLE_MEM_DEPTH = scm_pkg::MEM_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [scm_pkg::OP_W-1:0]            i_operation,
    input  wire logic signed [scm_pkg::SAMPLE_W-1:0] i_music_sample,
    input  wire logic [scm_pkg::CH_IN_W-1:0]         i_channel,
    input  wire logic [scm_pkg::LEVEL_W-1:0]         i_level,
    input  wire logic [scm_pkg::ADDR_W-1:0]          i_address,
    input  wire logic [scm_pkg::LEN_W-1:0]           i_length,
    input  wire logic signed [scm_pkg::BYTE_W-1:0]   i_byte_value,
    input  wire logic                                i_cfg_we,
    input  wire logic [scm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [scm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                     o_valid,
    output logic signed [scm_pkg::SAMPLE_W-1:0]      o_mixed_sample,
    output logic [scm_pkg::ACTIVE_W-1:0]             o_active_channels
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    scm_pkg::t_cmd   w_cmd;
    logic [CH_W-1:0] w_visit_ch;

    scm_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .o_busy      (busy),
        .o_cmd       (w_cmd),
        .o_visit_ch  (w_visit_ch)
    );

    scm_datapath #(
        .CHANNELS         (CHANNELS),
        .LEVELS           (LEVELS),
        .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_visit_ch        (w_visit_ch),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_music_sample    (i_music_sample),
        .i_channel         (i_channel),
        .i_level           (i_level),
        .i_address         (i_address),
        .i_length          (i_length),
        .i_byte_value      (i_byte_value),
        .o_valid           (o_valid),
        .o_mixed_sample    (o_mixed_sample),
        .o_active_channels (o_active_channels)
    );

endmodule

`default_nettype wire

[sv/scm_ctrl.sv]
// ----------------------------------------------------------------------------
// Sample channel mixer controller
// Decodes accepted operations and sequences a mix: one channel visit per
// cycle, a pipeline drain, then the result load.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_ctrl #(
    parameter int CHANNELS = scm_pkg::CHANNELS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [scm_pkg::OP_W-1:0]     i_operation,
    output logic                              o_busy,
    output scm_pkg::t_cmd                     o_cmd,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] o_visit_ch
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic [scm_pkg::DRAIN_W-1:0] LAST_DRAIN =
        scm_pkg::DRAIN_W'(scm_pkg::PIPE_DRAIN - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MIX    = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [CH_W-1:0]                r_cnt, n_cnt;
    logic [scm_pkg::DRAIN_W-1:0]    r_drain, n_drain;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_drain  = r_drain;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_operation)
                        scm_pkg::OP_MIX: begin
                            o_cmd.load_mix = 1'b1;
                            n_cnt          = '0;
                            n_state        = S_MIX;
                        end
                        scm_pkg::OP_START: o_cmd.do_start = 1'b1;
                        scm_pkg::OP_WRITE: o_cmd.do_write = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_MIX: begin
                o_cmd.visit = 1'b1;
                if (r_cnt == LAST_CH) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + CH_W'(1);
                end
            end
            S_DRAIN: begin
                if (r_drain == LAST_DRAIN) begin
                    n_state = S_FINISH;
                end else begin
                    n_drain = r_drain + scm_pkg::DRAIN_W'(1);
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_visit_ch = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drain <= n_drain;
        end
    end

endmodule

`default_nettype wire

[sv/scm_datapath.sv]
// ----------------------------------------------------------------------------
// Sample channel mixer datapath
// Configuration registers, channel state, sample memory, the per-channel
// gain and product pipeline, the accumulator and the output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_datapath #(
    parameter int CHANNELS         = scm_pkg::CHANNELS_DEF,
    parameter int LEVELS           = scm_pkg::LEVELS_DEF,
    parameter int SAMPLE_MEM_DEPTH = scm_pkg::MEM_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire scm_pkg::t_cmd                      i_cmd,
    input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_visit_ch,
    input  wire logic                               i_cfg_we,
    input  wire logic [scm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [scm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic signed [scm_pkg::SAMPLE_W-1:0] i_music_sample,
    input  wire logic [scm_pkg::CH_IN_W-1:0]        i_channel,
    input  wire logic [scm_pkg::LEVEL_W-1:0]        i_level,
    input  wire logic [scm_pkg::ADDR_W-1:0]         i_address,
    input  wire logic [scm_pkg::LEN_W-1:0]          i_length,
    input  wire logic signed [scm_pkg::BYTE_W-1:0]  i_byte_value,
    output logic                                    o_valid,
    output logic signed [scm_pkg::SAMPLE_W-1:0]     o_mixed_sample,
    output logic [scm_pkg::ACTIVE_W-1:0]            o_active_channels
);

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_AW   = $clog2(SAMPLE_MEM_DEPTH);
    localparam int OUT_CH   = (CHANNELS < scm_pkg::ACTIVE_W) ? CHANNELS : scm_pkg::ACTIVE_W;
    localparam int LEV_RECIP = (1 << scm_pkg::RECIP_SHIFT) / LEVELS;
    localparam int MEM_RECIP = (1 << scm_pkg::RECIP_SHIFT) / SAMPLE_MEM_DEPTH;
    localparam int LEV_MUL_W = scm_pkg::PROD_W + scm_pkg::RECIP_SHIFT;
    localparam int MEM_MUL_W = scm_pkg::ADDR_W + scm_pkg::RECIP_SHIFT;
    localparam int MQ_W      = 8;
    localparam int SH_W      = scm_pkg::ACC_W - scm_pkg::MIX_SHIFT;
    localparam int TERM_W    = scm_pkg::BYTE_W + scm_pkg::GAIN_W + 1;
    localparam int MPROD_W   = scm_pkg::SAMPLE_W + scm_pkg::GAIN_W + 2;
    localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(32767);
    localparam logic signed [SH_W-1:0] SAT_MIN = SH_W'(-32768);

    // Configuration registers.
    logic [scm_pkg::GAIN_W-1:0] r_music_gain, r_sample_gain;
    logic                       r_music_enable, r_sample_enable;
    logic [scm_pkg::STEP_W-1:0] r_sample_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_music_gain    <= scm_pkg::MUSIC_GAIN_RST;
            r_sample_gain   <= scm_pkg::SAMPLE_GAIN_RST;
            r_music_enable  <= 1'b1;
            r_sample_enable <= 1'b1;
            r_sample_step   <= scm_pkg::SAMPLE_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                scm_pkg::CFG_MUSIC_GAIN:    r_music_gain    <= i_cfg_data[scm_pkg::GAIN_W-1:0];
                scm_pkg::CFG_SAMPLE_GAIN:   r_sample_gain   <= i_cfg_data[scm_pkg::GAIN_W-1:0];
                scm_pkg::CFG_MUSIC_ENABLE:  r_music_enable  <= i_cfg_data[0];
                scm_pkg::CFG_SAMPLE_ENABLE: r_sample_enable <= i_cfg_data[0];
                scm_pkg::CFG_SAMPLE_STEP:   r_sample_step   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Channel state.
    logic [scm_pkg::ADDR_W-1:0]  r_ch_addr  [CHANNELS];
    logic [scm_pkg::LEN_W-1:0]   r_ch_rem   [CHANNELS];
    logic [scm_pkg::PHASE_W-1:0] r_ch_phase [CHANNELS];
    logic [scm_pkg::LEVEL_W-1:0] r_ch_lvl   [CHANNELS];

    logic                           w_start_ok;
    logic [CH_W-1:0]                w_start_ch;
    logic [scm_pkg::LEVEL_W-1:0]    w_start_lvl;
    logic [scm_pkg::ADDR_W-1:0]     w_sel_addr;
    logic [scm_pkg::LEN_W-1:0]      w_sel_rem;
    logic [scm_pkg::LEVEL_W-1:0]    w_sel_lvl;
    logic                           w_act;
    logic [scm_pkg::STEP_W:0]       w_phase_sum;
    logic [scm_pkg::ADV_W-1:0]      w_adv;

    assign w_start_ok  = r_sample_enable && (32'(i_channel) < CHANNELS);
    assign w_start_ch  = CH_W'(i_channel);
    assign w_start_lvl = (32'(i_level) >= LEVELS) ? scm_pkg::LEVEL_W'(LEVELS - 1) : i_level;

    assign w_sel_addr  = r_ch_addr[i_visit_ch];
    assign w_sel_rem   = r_ch_rem[i_visit_ch];
    assign w_sel_lvl   = r_ch_lvl[i_visit_ch];
    assign w_act       = i_cmd.visit && r_sample_enable && (w_sel_rem != '0);
    assign w_phase_sum = (scm_pkg::STEP_W + 1)'(r_ch_phase[i_visit_ch])
                       + (scm_pkg::STEP_W + 1)'(r_sample_step);
    assign w_adv       = w_phase_sum[scm_pkg::STEP_W:scm_pkg::PHASE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_ch_addr[i]  <= '0;
                r_ch_rem[i]   <= '0;
                r_ch_phase[i] <= '0;
                r_ch_lvl[i]   <= '0;
            end
        end else begin
            if (i_cmd.do_start && w_start_ok) begin
                r_ch_addr[w_start_ch]  <= i_address;
                r_ch_rem[w_start_ch]   <= i_length;
                r_ch_lvl[w_start_ch]   <= w_start_lvl;
                r_ch_phase[w_start_ch] <= '0;
            end
            if (w_act) begin
                r_ch_phase[i_visit_ch] <= w_phase_sum[scm_pkg::PHASE_W-1:0];
                if (w_adv != '0) begin
                    if (scm_pkg::LEN_W'(w_adv) >= w_sel_rem) begin
                        r_ch_rem[i_visit_ch] <= '0;
                    end else begin
                        r_ch_addr[i_visit_ch] <= w_sel_addr + scm_pkg::ADDR_W'(w_adv);
                        r_ch_rem[i_visit_ch]  <= w_sel_rem - scm_pkg::LEN_W'(w_adv);
                    end
                end
            end
        end
    end

    // Stage 1: memory address reduction estimate and gain-level product.
    // Writes and channel reads share the address reduction.
    logic [scm_pkg::ADDR_W-1:0]  w_red_addr;
    logic [MEM_MUL_W-1:0]        w_mem_mul;
    logic                        r1_rd, r1_wr;
    logic [scm_pkg::ADDR_W-1:0]  r1_addr;
    logic [MQ_W-1:0]             r1_mq;
    logic [scm_pkg::BYTE_W-1:0]  r1_wdata;
    logic [scm_pkg::PROD_W-1:0]  r1_prod;

    assign w_red_addr = i_cmd.do_write ? i_address : w_sel_addr;
    assign w_mem_mul  = MEM_MUL_W'(w_red_addr) * MEM_MUL_W'(MEM_RECIP);

    always_ff @(posedge i_clk) begin
        r1_addr  <= w_red_addr;
        r1_mq    <= w_mem_mul[scm_pkg::RECIP_SHIFT +: MQ_W];
        r1_wdata <= i_byte_value;
        r1_prod  <= scm_pkg::PROD_W'(r_sample_gain)
                  * scm_pkg::PROD_W'({1'b0, w_sel_lvl} + 4'd1);
    end

    // Stage 2: finish the address reduction, access memory, divide estimate.
    logic [scm_pkg::ADDR_W-1:0]  w_mem_rem;
    logic [MEM_AW-1:0]           w_mem_idx;
    logic [LEV_MUL_W-1:0]        w_lev_mul;
    logic [7:0]                  r_mem [SAMPLE_MEM_DEPTH];
    logic                        r2_v;
    logic signed [scm_pkg::BYTE_W-1:0] r2_byte;
    logic [scm_pkg::GAIN_W-1:0]  r2_est;
    logic [scm_pkg::PROD_W-1:0]  r2_prod;

    assign w_mem_rem = r1_addr - scm_pkg::ADDR_W'(32'(r1_mq) * SAMPLE_MEM_DEPTH);
    assign w_mem_idx = (32'(w_mem_rem) >= SAMPLE_MEM_DEPTH)
                     ? MEM_AW'(32'(w_mem_rem) - SAMPLE_MEM_DEPTH)
                     : MEM_AW'(w_mem_rem);
    assign w_lev_mul = LEV_MUL_W'(r1_prod) * LEV_MUL_W'(LEV_RECIP);

    always_ff @(posedge i_clk) begin
        if (r1_wr) begin
            r_mem[w_mem_idx] <= r1_wdata;
        end
        if (r1_rd) begin
            r2_byte <= $signed(r_mem[w_mem_idx]);
        end
        r2_est  <= w_lev_mul[scm_pkg::RECIP_SHIFT +: scm_pkg::GAIN_W];
        r2_prod <= r1_prod;
    end

    // Stage 3: the estimate is at most one short of the true quotient.
    logic [scm_pkg::PROD_W-1:0]  w_lev_rem;
    logic [scm_pkg::GAIN_W-1:0]  r3_q;
    logic signed [scm_pkg::BYTE_W-1:0] r3_byte;
    logic                        r3_v;

    assign w_lev_rem = r2_prod - scm_pkg::PROD_W'(32'(r2_est) * LEVELS);

    always_ff @(posedge i_clk) begin
        r3_q    <= r2_est + scm_pkg::GAIN_W'(32'(w_lev_rem) >= LEVELS);
        r3_byte <= r2_byte;
    end

    // Stage 4: channel product.
    logic signed [TERM_W-1:0] r4_term;
    logic                     r4_v;

    always_ff @(posedge i_clk) begin
        r4_term <= TERM_W'(r3_byte) * $signed(TERM_W'(r3_q));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_rd <= 1'b0;
            r1_wr <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
        end else begin
            r1_rd <= w_act;
            r1_wr <= i_cmd.do_write;
            r2_v  <= r1_rd;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
        end
    end

    // Accumulator, loaded when a mix starts with the scaled music sample, or zero when music is disabled.
    logic signed [MPROD_W-1:0]        w_mprod;
    logic signed [scm_pkg::ACC_W-1:0] r_acc;

    assign w_mprod = MPROD_W'(i_music_sample)
                   * $signed(MPROD_W'({r_music_gain, 1'b0}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mix) begin
            r_acc <= r_music_enable ? scm_pkg::ACC_W'(w_mprod) : '0;
        end else if (r4_v) begin
            r_acc <= r_acc + (scm_pkg::ACC_W'(r4_term) <<< scm_pkg::BYTE_SHIFT);
        end
    end

    // Result: arithmetic shift, saturation and the channel activity mask.
    logic signed [SH_W-1:0]             w_sh;
    logic signed [scm_pkg::SAMPLE_W-1:0] w_sat;
    logic [scm_pkg::ACTIVE_W-1:0]       w_active;
    logic                               r_out_valid;
    logic signed [scm_pkg::SAMPLE_W-1:0] r_out_sample;
    logic [scm_pkg::ACTIVE_W-1:0]       r_out_active;

    assign w_sh = SH_W'(r_acc >>> scm_pkg::MIX_SHIFT);

    always_comb begin
        if (w_sh > SAT_MAX) begin
            w_sat = scm_pkg::SAMPLE_W'(SAT_MAX);
        end else if (w_sh < SAT_MIN) begin
            w_sat = scm_pkg::SAMPLE_W'(SAT_MIN);
        end else begin
            w_sat = scm_pkg::SAMPLE_W'(w_sh);
        end
    end

    always_comb begin
        w_active = '0;
        for (int i = 0; i < OUT_CH; i++) begin
            w_active[i] = (r_ch_rem[i] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_sample <= w_sat;
            r_out_active <= w_active;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_mixed_sample    = r_out_sample;
    assign o_active_channels = r_out_active;

endmodule

`default_nettype wire
